@@ rtl/core/tic_pkg.sv @@
// ----------------------------------------------------------------------------
// tic_pkg
// Shared constants and helper functions for the tweaked IDEA cipher core.
// ----------------------------------------------------------------------------
package tic_pkg;

  localparam int unsigned IndexBitsDefault = 28;
  localparam int unsigned NumSubkeys       = 52;
  localparam int unsigned NumRounds        = 8;
  localparam logic [15:0] SubkeyXor        = 16'h0dae;
  localparam int unsigned TweakLowKey      = 22;
  localparam int unsigned TweakHighKey     = 28;

  typedef logic [15:0] word_t;
  typedef word_t subkeys_t [NumSubkeys];

  typedef enum logic [0:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } reg_index_t;

  // Reduction of a registered 32-bit product modulo 65537 (0 stands for 65536).
  function automatic word_t mul_reduce(input logic [31:0] p, input word_t x, input word_t y);
    word_t lo;
    word_t hi;
    begin
      lo = p[15:0];
      hi = p[31:16];
      if (p == 32'd0) begin
        mul_reduce = 16'd1 - x - y;
      end else if (lo >= hi) begin
        mul_reduce = lo - hi;
      end else begin
        mul_reduce = lo - hi + 16'd1;
      end
    end
  endfunction

  // Full key schedule: 25-bit rotations of the 128-bit key, then the XOR mask.
  function automatic subkeys_t expand(input logic [63:0] kh, input logic [63:0] kl);
    logic [127:0] key;
    subkeys_t     k;
    begin
      key = {kh, kl};
      for (int i = 0; i < NumSubkeys; i++) begin
        k[i] = key[127 - 16 * (i % 8) -: 16] ^ SubkeyXor;
        if (i % 8 == 7) begin
          key = {key[102:0], key[127:103]};
        end
      end
      expand = k;
    end
  endfunction

endpackage

@@ rtl/core/tic_mul_stage.sv @@
// ----------------------------------------------------------------------------
// tic_mul_stage
// Two-stage modulo-65537 multiplier with a hold enable: product, then reduction.
// ----------------------------------------------------------------------------
module tic_mul_stage (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] a,
  input  logic [15:0] b,
  output logic [15:0] prod
);

  logic [31:0] raw;
  logic [15:0] a_q;
  logic [15:0] b_q;

  // The operands travel with the raw product because a zero product needs them.
  always_ff @(posedge clk) begin
    if (en) begin
      raw  <= a * b;
      a_q  <= a;
      b_q  <= b;
      prod <= tic_pkg::mul_reduce(raw, a_q, b_q);
    end
  end

endmodule

@@ rtl/core/tweaked_idea_block_cipher_core.sv @@
// ----------------------------------------------------------------------------
// tweaked_idea_block_cipher_core
// Eight IDEA rounds plus output transform, one block per cycle while the output
// is taken, with a per-block tweak of subkeys 22 and 28 by the block index.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Payload
// s_axis    in         tdata = {data_in[63:0], block_index[INDEX_BITS-1:0]} padded
// m_axis    out        tdata = data_out[63:0]
// cfg       in         cfg_index (register), cfg_data (64-bit key half)
//
// Each round takes seven register levels: the x1 and x4 multiplies, the
// multiply by subkey 4 and the multiply by subkey 5 take two each (product,
// then reduction), and the mix takes one. The output transform adds three:
// a multiply (product, then reduction) and the output register.
// One block is accepted in every cycle while the output is taken. A stall on
// the master side freezes the whole pipeline, so nothing is lost or repeated.
// Reset clears the key registers and the valid bits and holds both ready outputs
// low; the subkeys are wired from the key registers and need no clearing pass.
module tweaked_idea_block_cipher_core #(
  parameter int unsigned INDEX_BITS = tic_pkg::IndexBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // bits from lowest: block_index[INDEX_BITS-1:0], data_in[63:0], zero pad
  input  logic [((INDEX_BITS + 64 + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // bits from lowest: data_out[63:0]
  output logic [63:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] key_high;
  logic [63:0] key_low;
  tic_pkg::subkeys_t subkeys;
  logic adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_valid) begin
      unique case (tic_pkg::reg_index_t'(cfg_index))
        tic_pkg::REG_KEY_HIGH: key_high <= cfg_data;
        tic_pkg::REG_KEY_LOW:  key_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The schedule is only rotations and an XOR, so the subkeys are plain wiring
  // and a new key applies to the very next block.
  always_comb begin
    subkeys = tic_pkg::expand(key_high, key_low);
  end

  assign cfg_ready     = !rst;
  assign adv           = m_axis_tready || !m_axis_tvalid;
  assign s_axis_tready = adv && !rst;

  // Tweak computed at the input and carried along.
  logic [INDEX_BITS-1:0] idx_in;
  logic [32:0]           tw_sum;
  assign idx_in = s_axis_tdata[INDEX_BITS-1:0];
  assign tw_sum = 33'(subkeys[tic_pkg::TweakLowKey]) + 33'(idx_in);

  logic [15:0] k22 [tic_pkg::NumRounds + 1];
  logic [15:0] k28 [tic_pkg::NumRounds + 1];
  logic [15:0] x1 [tic_pkg::NumRounds + 1];
  logic [15:0] x2 [tic_pkg::NumRounds + 1];
  logic [15:0] x3 [tic_pkg::NumRounds + 1];
  logic [15:0] x4 [tic_pkg::NumRounds + 1];

  assign k22[0] = tw_sum[15:0];
  assign k28[0] = subkeys[tic_pkg::TweakHighKey] + tw_sum[31:16];
  assign x1[0]  = s_axis_tdata[INDEX_BITS + 48 +: 16];
  assign x2[0]  = s_axis_tdata[INDEX_BITS + 32 +: 16];
  assign x3[0]  = s_axis_tdata[INDEX_BITS + 16 +: 16];
  assign x4[0]  = s_axis_tdata[INDEX_BITS +: 16];

  function automatic logic [15:0] key_at(input int unsigned n, input logic [15:0] t22,
                                         input logic [15:0] t28,
                                         input tic_pkg::subkeys_t sk);
    begin
      if (n == tic_pkg::TweakLowKey) key_at = t22;
      else if (n == tic_pkg::TweakHighKey) key_at = t28;
      else key_at = sk[n];
    end
  endfunction

  for (genvar r = 0; r < tic_pkg::NumRounds; r++) begin : g_round
    // Stage A: multiplies of x1 and x4, adds on x2 and x3.
    logic [15:0] m1, m4;
    logic [15:0] a2q, a3q, a2r, a3r, k22a, k28a, k22b, k28b;
    tic_mul_stage u_m1 (.clk(clk), .en(adv), .a(x1[r]),
      .b(key_at(6*r, k22[r], k28[r], subkeys)), .prod(m1));
    tic_mul_stage u_m4 (.clk(clk), .en(adv), .a(x4[r]),
      .b(key_at(6*r+3, k22[r], k28[r], subkeys)), .prod(m4));
    always_ff @(posedge clk) begin
      if (adv) begin
        a2q  <= x2[r] + key_at(6*r+1, k22[r], k28[r], subkeys);
        a3q  <= x3[r] + key_at(6*r+2, k22[r], k28[r], subkeys);
        k22a <= k22[r]; k28a <= k28[r];
        a2r  <= a2q; a3r <= a3q; k22b <= k22a; k28b <= k28a;
      end
    end
    // Stage B: t0 = (m1 ^ a3) * k4.
    logic [15:0] t0, m1c, m4c, a2s, a3s, k22c, k28c, k22d, k28d, m1d, m4d, a2t, a3t;
    tic_mul_stage u_t0 (.clk(clk), .en(adv), .a(m1 ^ a3r),
      .b(key_at(6*r+4, k22b, k28b, subkeys)), .prod(t0));
    always_ff @(posedge clk) begin
      if (adv) begin
        m1c <= m1; m4c <= m4; a2s <= a2r; a3s <= a3r; k22c <= k22b; k28c <= k28b;
        m1d <= m1c; m4d <= m4c; a2t <= a2s; a3t <= a3s; k22d <= k22c; k28d <= k28c;
      end
    end
    // Stage C: t1 = ((a2 ^ m4) + t0) * k5.
    logic [15:0] t1, t0q, m1e, m4e, a2u, a3u, k22e, k28e;
    logic [15:0] t0r, m1g, m4g, a2v, a3v, k22g, k28g;
    tic_mul_stage u_t1 (.clk(clk), .en(adv), .a((a2t ^ m4d) + t0),
      .b(key_at(6*r+5, k22d, k28d, subkeys)), .prod(t1));
    always_ff @(posedge clk) begin
      if (adv) begin
        t0q <= t0; m1e <= m1d; m4e <= m4d; a2u <= a2t; a3u <= a3t;
        k22e <= k22d; k28e <= k28d;
        t0r <= t0q; m1g <= m1e; m4g <= m4e; a2v <= a2u; a3v <= a3u;
        k22g <= k22e; k28g <= k28e;
      end
    end
    // Mix (registered): fold t1 and t0 + t1 back into the four words.
    logic [15:0] s0;
    assign s0 = t0r + t1;
    logic [15:0] y1, y2, y3, y4, k22f, k28f;
    always_ff @(posedge clk) begin
      if (adv) begin
        y1 <= m1g ^ t1; y2 <= a3v ^ t1; y3 <= a2v ^ s0; y4 <= m4g ^ s0;
        k22f <= k22g; k28f <= k28g;
      end
    end
    assign x1[r+1] = y1; assign x2[r+1] = y2; assign x3[r+1] = y3; assign x4[r+1] = y4;
    assign k22[r+1] = k22f; assign k28[r+1] = k28f;
  end

  // Output transform: registered multiplies (product, then reduction), adds delayed to match.
  localparam int unsigned R = tic_pkg::NumRounds;
  logic [15:0] o1, o4, o2q, o3q, o2r, o3r;
  tic_mul_stage u_o1 (.clk(clk), .en(adv), .a(x1[R]), .b(subkeys[48]), .prod(o1));
  tic_mul_stage u_o4 (.clk(clk), .en(adv), .a(x4[R]), .b(subkeys[51]), .prod(o4));
  always_ff @(posedge clk) begin
    if (adv) begin
      o2q <= x3[R] + subkeys[49];
      o3q <= x2[R] + subkeys[50];
      o2r <= o2q; o3r <= o3q;
    end
  end
  logic [63:0] out_q;
  always_ff @(posedge clk) begin
    if (adv) begin
      out_q <= {o1, o2r, o3r, o4};
    end
  end

  // Seven register levels per round and three for the output transform.
  localparam int unsigned Lat = tic_pkg::NumRounds * 7 + 3;
  logic [Lat-1:0] vpipe;
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (adv) begin
      vpipe <= {vpipe[Lat-2:0], s_axis_tvalid};
    end
  end

  assign m_axis_tvalid = vpipe[Lat-1];
  assign m_axis_tdata  = out_q;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");
  a_vfreeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vpipe))
    else $error("pipeline moved during stall");

endmodule
